@@ sv/uvp_pkg.sv @@
`default_nettype none
package uvp_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int DUTY_W        = 8;
  localparam int TIMER_W       = 16;
  localparam int FAIL_W        = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int IN_DATA_W     = 56;
  localparam int OUT_DATA_W    = 32;

  localparam logic [TIMER_W-1:0] STATUS_PERIOD = TIMER_W'(500);
  localparam logic [TIMER_W-1:0] TIMER_MAX     = '1;
  localparam logic [FAIL_W-1:0]  FAIL_MAX      = '1;

  typedef enum logic [1:0] {
    MODE_RUN = 2'd0,
    MODE_ERR = 2'd1,
    MODE_REC = 2'd2
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_UV_A     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UV_B     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_0   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_1   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_2   = 3'd7;

  typedef logic [2:0][DUTY_W-1:0] duty_set_t;

endpackage
`default_nettype wire

@@ sv/undervoltage_protection_fsm.sv @@
// Undervoltage protection for a three-channel LED driver. Each input beat is
// one millisecond tick carrying both rail readings, an optional duty command
// and the flash hold flag; each tick produces exactly one result beat. The
// whole tick is evaluated combinationally straight into the output
// register, so the block takes one beat per cycle and the result appears in the
// cycle after acceptance; the only thing that slows input is a full output
// register whose beat is not taken. Configuration is written through the
// cfg_ port while no tick is in flight; writing a start duty also loads the
// commanded duty, and the applied duty when the block is running.
`default_nettype none
module undervoltage_protection_fsm
  import uvp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // tdata: rail_a_sample[11:0], rail_b_sample[23:12], cmd_valid[24],
  //        cmd_duty_0[32:25], cmd_duty_1[40:33], cmd_duty_2[48:41],
  //        flash_hold[49], zero fill[55:50]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // tdata: mode_code[1:0], fault_flags[3:2], buck_on[4], drive_duty_0[12:5],
  //        drive_duty_1[20:13], drive_duty_2[28:21], status_pulse[29],
  //        zero fill[31:30]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [SAMPLE_BITS-1:0] uv_a_r, uv_b_r;
  logic [FAIL_W-1:0]      debounce_r;
  logic [TIMER_W-1:0]     sample_int_r, rec_wait_r;

  // Tick state.
  mode_t              mode_r, mode_nxt;
  logic [1:0]         faults_r, faults_nxt;
  logic [FAIL_W-1:0]  fail_r, fail_nxt;
  logic [TIMER_W-1:0] samp_tmr_r, samp_tmr_nxt;
  logic [TIMER_W-1:0] stat_tmr_r, stat_tmr_nxt;
  logic [TIMER_W-1:0] rec_tmr_r, rec_tmr_nxt;
  duty_set_t          cmd_duty_r, cmd_duty_nxt;
  duty_set_t          app_duty_r, app_duty_nxt;
  logic               pend_r, pend_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                   in_beat;
  logic [SAMPLE_BITS-1:0] rail_a, rail_b;
  logic                   cmd_valid, hold;
  duty_set_t              cmd_in;
  logic [1:0]             err;
  logic                   pulse, to_err, to_rec;
  logic [TIMER_W-1:0]     samp_inc, stat_inc, rec_inc;
  logic [FAIL_W-1:0]      fail_inc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign rail_a    = in_tdata[11:0];
  assign rail_b    = in_tdata[23:12];
  assign cmd_valid = in_tdata[24];
  assign cmd_in[0] = in_tdata[32:25];
  assign cmd_in[1] = in_tdata[40:33];
  assign cmd_in[2] = in_tdata[48:41];
  assign hold      = in_tdata[49];

  // A zero threshold turns its rail check off.
  assign err[0] = (uv_a_r != '0) && (rail_a < uv_a_r);
  assign err[1] = (uv_b_r != '0) && (rail_b < uv_b_r);

  assign samp_inc = (samp_tmr_r == TIMER_MAX) ? samp_tmr_r : samp_tmr_r + 1'b1;
  assign stat_inc = (stat_tmr_r == TIMER_MAX) ? stat_tmr_r : stat_tmr_r + 1'b1;
  assign rec_inc  = (rec_tmr_r == TIMER_MAX) ? rec_tmr_r : rec_tmr_r + 1'b1;
  assign fail_inc = (fail_r == FAIL_MAX) ? fail_r : fail_r + 1'b1;

  always_comb begin
    mode_nxt     = mode_r;
    faults_nxt   = faults_r;
    fail_nxt     = fail_r;
    samp_tmr_nxt = samp_tmr_r;
    stat_tmr_nxt = stat_tmr_r;
    rec_tmr_nxt  = rec_tmr_r;
    cmd_duty_nxt = cmd_duty_r;
    app_duty_nxt = app_duty_r;
    pend_nxt     = pend_r;
    pulse        = 1'b0;
    to_err       = 1'b0;
    to_rec       = 1'b0;

    if (in_beat) begin
      if (cmd_valid) begin
        cmd_duty_nxt = cmd_in;
        pend_nxt     = 1'b1;
      end
      samp_tmr_nxt = samp_inc;
      stat_tmr_nxt = stat_inc;
      rec_tmr_nxt  = rec_inc;

      case (mode_r)
        MODE_RUN: begin
          if (!hold) begin
            if (samp_inc >= sample_int_r) begin
              samp_tmr_nxt = '0;
              if (err != 2'b00) begin
                if (fail_inc >= debounce_r) begin
                  fail_nxt     = '0;
                  mode_nxt     = MODE_ERR;
                  faults_nxt   = err;
                  app_duty_nxt = '0;
                  to_err       = 1'b1;
                end else begin
                  fail_nxt = fail_inc;
                end
              end else begin
                fail_nxt = '0;
              end
            end
            if (!to_err) begin
              if (stat_inc >= STATUS_PERIOD) begin
                stat_tmr_nxt = '0;
                pulse        = 1'b1;
              end
              if (pend_nxt) begin
                app_duty_nxt = cmd_duty_nxt;
                pend_nxt     = 1'b0;
              end
            end
          end
        end
        MODE_ERR: begin
          if (samp_inc >= sample_int_r) begin
            samp_tmr_nxt = '0;
            if (err == 2'b00) begin
              mode_nxt    = MODE_REC;
              rec_tmr_nxt = '0;
              to_rec      = 1'b1;
            end
          end
          if (!to_rec && stat_inc >= STATUS_PERIOD) begin
            stat_tmr_nxt = '0;
            pulse        = 1'b1;
          end
        end
        MODE_REC: begin
          if (rec_inc >= rec_wait_r) begin
            if (err == 2'b00) begin
              mode_nxt     = MODE_RUN;
              faults_nxt   = 2'b00;
              fail_nxt     = '0;
              samp_tmr_nxt = '0;
              stat_tmr_nxt = '0;
              app_duty_nxt = cmd_duty_nxt;
            end else begin
              mode_nxt     = MODE_ERR;
              faults_nxt   = err;
              app_duty_nxt = '0;
            end
          end
        end
        default: begin
          mode_nxt = MODE_RUN;
        end
      endcase
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DUTY_0: begin
          cmd_duty_nxt[0] = cfg_wdata[DUTY_W-1:0];
          if (mode_r == MODE_RUN) app_duty_nxt[0] = cfg_wdata[DUTY_W-1:0];
        end
        CFG_DUTY_1: begin
          cmd_duty_nxt[1] = cfg_wdata[DUTY_W-1:0];
          if (mode_r == MODE_RUN) app_duty_nxt[1] = cfg_wdata[DUTY_W-1:0];
        end
        CFG_DUTY_2: begin
          cmd_duty_nxt[2] = cfg_wdata[DUTY_W-1:0];
          if (mode_r == MODE_RUN) app_duty_nxt[2] = cfg_wdata[DUTY_W-1:0];
        end
        default: begin
        end
      endcase
    end

    out_data_nxt = {2'b00, pulse, app_duty_nxt[2], app_duty_nxt[1], app_duty_nxt[0],
                    (mode_nxt != MODE_ERR), faults_nxt, mode_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uv_a_r       <= '0;
      uv_b_r       <= '0;
      debounce_r   <= FAIL_W'(3);
      sample_int_r <= TIMER_W'(100);
      rec_wait_r   <= TIMER_W'(200);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UV_A:     uv_a_r       <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_UV_B:     uv_b_r       <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_DEBOUNCE: debounce_r   <= cfg_wdata[FAIL_W-1:0];
        CFG_SAMPLE:   sample_int_r <= cfg_wdata[TIMER_W-1:0];
        CFG_RECOVERY: rec_wait_r   <= cfg_wdata[TIMER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_RUN;
      faults_r   <= 2'b00;
      fail_r     <= '0;
      samp_tmr_r <= '0;
      stat_tmr_r <= '0;
      rec_tmr_r  <= '0;
      cmd_duty_r <= '0;
      app_duty_r <= '0;
      pend_r     <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      faults_r   <= faults_nxt;
      fail_r     <= fail_nxt;
      samp_tmr_r <= samp_tmr_nxt;
      stat_tmr_r <= stat_tmr_nxt;
      rec_tmr_r  <= rec_tmr_nxt;
      cmd_duty_r <= cmd_duty_nxt;
      app_duty_r <= app_duty_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_beat) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_data_r <= out_data_nxt;
    end
  end

  // The LEDs are dark whenever the block sits in error.
  a_err_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ERR) |-> (app_duty_r == '0))
    else $error("applied duty nonzero in error mode");

  // Faults are latched exactly while the block is out of the running mode.
  a_fault_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_RUN) == (faults_r == 2'b00))
    else $error("fault flags disagree with mode");

  // Recovery never broadcasts status.
  a_no_rec_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[29]) |-> (out_data_r[1:0] != MODE_REC))
    else $error("status pulse raised in recovery");

endmodule
`default_nettype wire

@@ tb/tb_undervoltage_protection_fsm.sv @@
module tb_undervoltage_protection_fsm;
  import uvp_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int PHASE_TICKS = 108;

  typedef struct packed {
    logic [5:0]             pad;
    logic                   hold;
    duty_set_t              duty;
    logic                   cmd_valid;
    logic [SAMPLE_BITS-1:0] rail_b;
    logic [SAMPLE_BITS-1:0] rail_a;
  } tick_t;

  typedef struct packed {
    logic [1:0] pad;
    logic       pulse;
    duty_set_t  duty;
    logic       buck;
    logic [1:0] faults;
    mode_t      mode;
  } status_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {RDY_ALWAYS, RDY_HALF, RDY_SPARSE} ready_style_t;

  typedef struct packed {
    row_kind_t             kind;
    tick_t                 tick;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    logic                  typed;
    status_t               want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_UV_A;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  undervoltage_protection_fsm i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Register copies kept alongside the block.
  logic [SAMPLE_BITS-1:0] c_uv_a, c_uv_b;
  logic [FAIL_W-1:0]      c_debounce;
  logic [TIMER_W-1:0]     c_sample_ms, c_recov_ms;

  // Protection state as the block should hold it.
  mode_t              m_mode;
  logic [1:0]         m_faults;
  logic [FAIL_W-1:0]  m_miss_cnt;
  logic [TIMER_W-1:0] m_sample_tmr, m_status_tmr, m_recov_tmr;
  duty_set_t          m_cmd_duty, m_drive_duty;
  logic               m_cmd_pending;

  status_t status_due[$];
  row_t    dir_rows[$];
  int      n_mismatch = 0;
  int      cycle_cnt = 0;
  int      burst_left = 0;
  bit      fail_streak = 1'b0;
  int      streak_left = 0;

  ready_style_t rdy_style = RDY_ALWAYS;
  int           rdy_left = 0;

  function automatic void reset_protection();
    c_uv_a        = '0;
    c_uv_b        = '0;
    c_debounce    = 8'd3;
    c_sample_ms   = 16'd100;
    c_recov_ms    = 16'd200;
    m_mode        = MODE_RUN;
    m_faults      = '0;
    m_miss_cnt    = '0;
    m_sample_tmr  = '0;
    m_status_tmr  = '0;
    m_recov_tmr   = '0;
    m_cmd_duty    = '0;
    m_drive_duty  = '0;
    m_cmd_pending = 1'b0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    int k;
    case (idx)
      CFG_UV_A:     c_uv_a = val[SAMPLE_BITS-1:0];
      CFG_UV_B:     c_uv_b = val[SAMPLE_BITS-1:0];
      CFG_DEBOUNCE: c_debounce = val[FAIL_W-1:0];
      CFG_SAMPLE:   c_sample_ms = val;
      CFG_RECOVERY: c_recov_ms = val;
      default: begin
        // A start duty also reloads the commanded duty, and the drive when running.
        k = int'(idx - CFG_DUTY_0);
        m_cmd_duty[k] = val[DUTY_W-1:0];
        if (m_mode == MODE_RUN) m_drive_duty[k] = val[DUTY_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [1:0] low_rails(logic [SAMPLE_BITS-1:0] a, logic [SAMPLE_BITS-1:0] b);
    logic [1:0] err;
    err = '0;
    if (c_uv_a != 0 && a < c_uv_a) err[0] = 1'b1;
    if (c_uv_b != 0 && b < c_uv_b) err[1] = 1'b1;
    return err;
  endfunction

  function automatic logic [TIMER_W-1:0] bump(logic [TIMER_W-1:0] t);
    return (t == TIMER_MAX) ? t : t + 1'b1;
  endfunction

  function automatic status_t step_protection(tick_t t);
    logic [1:0] err;
    logic       pulse, left_run, left_err;
    status_t    r;
    pulse    = 1'b0;
    left_run = 1'b0;
    left_err = 1'b0;
    if (t.cmd_valid) begin
      m_cmd_duty    = t.duty;
      m_cmd_pending = 1'b1;
    end
    m_sample_tmr = bump(m_sample_tmr);
    m_status_tmr = bump(m_status_tmr);
    m_recov_tmr  = bump(m_recov_tmr);
    case (m_mode)
      MODE_RUN: begin
        if (!t.hold) begin
          if (m_sample_tmr >= c_sample_ms) begin
            m_sample_tmr = '0;
            err = low_rails(t.rail_a, t.rail_b);
            if (err != 0) begin
              if (m_miss_cnt != FAIL_MAX) m_miss_cnt = m_miss_cnt + 1'b1;
              if (m_miss_cnt >= c_debounce) begin
                m_miss_cnt   = '0;
                m_mode       = MODE_ERR;
                m_faults     = err;
                m_drive_duty = '0;
                left_run     = 1'b1;
              end
            end else begin
              m_miss_cnt = '0;
            end
          end
          if (!left_run) begin
            if (m_status_tmr >= STATUS_PERIOD) begin
              m_status_tmr = '0;
              pulse = 1'b1;
            end
            if (m_cmd_pending) begin
              m_drive_duty  = m_cmd_duty;
              m_cmd_pending = 1'b0;
            end
          end
        end
      end
      MODE_ERR: begin
        if (m_sample_tmr >= c_sample_ms) begin
          m_sample_tmr = '0;
          if (low_rails(t.rail_a, t.rail_b) == 0) begin
            m_mode      = MODE_REC;
            m_recov_tmr = '0;
            left_err    = 1'b1;
          end
        end
        if (!left_err && m_status_tmr >= STATUS_PERIOD) begin
          m_status_tmr = '0;
          pulse = 1'b1;
        end
      end
      default: begin
        if (m_recov_tmr >= c_recov_ms) begin
          err = low_rails(t.rail_a, t.rail_b);
          if (err == 0) begin
            m_mode       = MODE_RUN;
            m_faults     = '0;
            m_miss_cnt   = '0;
            m_sample_tmr = '0;
            m_status_tmr = '0;
            m_drive_duty = m_cmd_duty;
          end else begin
            m_mode       = MODE_ERR;
            m_faults     = err;
            m_drive_duty = '0;
          end
        end
      end
    endcase
    r        = '0;
    r.mode   = m_mode;
    r.faults = m_faults;
    r.buck   = (m_mode != MODE_ERR);
    r.duty   = m_drive_duty;
    r.pulse  = pulse;
    return r;
  endfunction

  function automatic row_t tick_row(logic [SAMPLE_BITS-1:0] a, logic [SAMPLE_BITS-1:0] b,
                                    logic cv, duty_set_t d, logic hold);
    row_t r;
    r                = '0;
    r.kind           = ROW_TICK;
    r.tick.rail_a    = a;
    r.tick.rail_b    = b;
    r.tick.cmd_valid = cv;
    r.tick.duty      = d;
    r.tick.hold      = hold;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  // Running with no fault and no pulse, driving the given duties.
  function automatic row_t fixed_run(row_t r, duty_set_t d);
    r.typed     = 1'b1;
    r.want      = '0;
    r.want.mode = MODE_RUN;
    r.want.buck = 1'b1;
    r.want.duty = d;
    return r;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_rail(logic [SAMPLE_BITS-1:0] thr, bit low);
    if (thr == 0 || $urandom_range(0, 6) == 0) return SAMPLE_BITS'($urandom);
    if (low) begin
      return ($urandom_range(0, 1) != 0) ? thr - 1'b1 : SAMPLE_BITS'($urandom_range(0, thr - 1));
    end
    return ($urandom_range(0, 1) != 0) ? thr : SAMPLE_BITS'($urandom_range(thr, 4095));
  endfunction

  // Rails come in streaks of low or healthy readings so that the debounce,
  // error and recovery paths are all walked through end to end.
  function automatic tick_t random_tick();
    tick_t   t;
    int      sel;
    if (streak_left == 0) begin
      fail_streak = ($urandom_range(0, 1) != 0);
      streak_left = fail_streak ? $urandom_range(1, 8) : $urandom_range(1, 30);
    end
    streak_left--;
    sel         = fail_streak ? $urandom_range(1, 3) : 0;
    t           = '0;
    t.rail_a    = pick_rail(c_uv_a, sel[0]);
    t.rail_b    = pick_rail(c_uv_b, sel[1]);
    t.cmd_valid = ($urandom_range(0, 3) == 0);
    t.duty      = 24'($urandom);
    t.hold      = ($urandom_range(0, 7) == 0);
    return t;
  endfunction

  task automatic send_tick(tick_t t, logic typed, status_t want);
    status_t r;
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    do @(posedge clk); while (!in_tready);
    r = step_protection(t);
    status_due.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Registers change only with nothing in flight.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (status_due.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    apply_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic program_phase(int p);
    logic [SAMPLE_BITS-1:0] ua, ub;
    logic [FAIL_W-1:0]      db;
    logic [TIMER_W-1:0]     sm, rc;
    duty_set_t              sd;
    ua = SAMPLE_BITS'($urandom_range(800, 3500));
    ub = SAMPLE_BITS'($urandom_range(800, 3500));
    db = FAIL_W'($urandom_range(1, 4));
    sm = TIMER_W'($urandom_range(1, 4));
    rc = TIMER_W'($urandom_range(1, 10));
    sd = 24'($urandom);
    case (p)
      1: begin
        ua = '1;
        ub = '1;
        db = '1;
        sm = '1;
        rc = '1;
        sd = '1;
      end
      2: begin
        ua = SAMPLE_BITS'(1);
        ub = SAMPLE_BITS'(1);
        db = FAIL_W'(1);
        sm = TIMER_W'(1);
        rc = TIMER_W'(1);
        sd = '0;
      end
      3: begin
        ua = '0;
        db = FAIL_W'($urandom_range(1, 3));
        sm = TIMER_W'($urandom_range(0, 2));
        rc = TIMER_W'($urandom_range(0, 3));
      end
      4: begin
        ub = '0;
        db = FAIL_W'($urandom_range(0, 2));
        sm = TIMER_W'($urandom_range(1, 3));
        rc = TIMER_W'($urandom_range(1, 6));
      end
      default: ;
    endcase
    write_reg(CFG_UV_A, CFG_DATA_W'(ua));
    write_reg(CFG_UV_B, CFG_DATA_W'(ub));
    write_reg(CFG_DEBOUNCE, CFG_DATA_W'(db));
    write_reg(CFG_SAMPLE, sm);
    write_reg(CFG_RECOVERY, rc);
    write_reg(CFG_DUTY_0, CFG_DATA_W'(sd[0]));
    write_reg(CFG_DUTY_1, CFG_DATA_W'(sd[1]));
    write_reg(CFG_DUTY_2, CFG_DATA_W'(sd[2]));
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_mismatch++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    status_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = status_t'(out_tdata);
      if (status_due.size() == 0) begin
        $error("result beat with no tick waiting: %h", out_tdata);
        n_mismatch++;
      end else begin
        want = status_due.pop_front();
        check_field("mode_code", want.mode, got.mode);
        check_field("fault_flags", want.faults, got.faults);
        check_field("buck_on", want.buck, got.buck);
        check_field("drive_duty_0", want.duty[0], got.duty[0]);
        check_field("drive_duty_1", want.duty[1], got.duty[1]);
        check_field("drive_duty_2", want.duty[2], got.duty[2]);
        check_field("status_pulse", want.pulse, got.pulse);
        check_field("zero fill", want.pad, got.pad);
      end
    end
  end

  // The receiver switches between a few stall styles for random stretches.
  always @(negedge clk) begin
    if (rdy_left == 0) begin
      rdy_style = ready_style_t'($urandom_range(0, 2));
      rdy_left  = $urandom_range(4, 50);
    end
    rdy_left--;
    case (rdy_style)
      RDY_ALWAYS: out_tready <= 1'b1;
      RDY_HALF:   out_tready <= ($urandom_range(0, 1) != 0);
      default:    out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("undervoltage_protection_fsm: mismatch");
      $finish;
    end
  end

  initial begin
    reset_protection();

    // Reset defaults leave both rail checks off, so only the command path acts.
    dir_rows.push_back(fixed_run(tick_row(12'hFFF, 12'hFFF, 1'b1, '1, 1'b0), '1));
    dir_rows.push_back(fixed_run(tick_row(12'h000, 12'h000, 1'b0, '0, 1'b0), '1));
    dir_rows.push_back(fixed_run(tick_row(12'h000, 12'hFFF, 1'b1,
                                          {8'h7F, 8'h80, 8'h01}, 1'b1), '1));
    dir_rows.push_back(fixed_run(tick_row(12'hFFF, 12'h000, 1'b0, '0, 1'b0),
                                 {8'h7F, 8'h80, 8'h01}));
    dir_rows.push_back(cfg_row(CFG_UV_A, 16'd2048));
    dir_rows.push_back(cfg_row(CFG_UV_B, 16'd1024));
    dir_rows.push_back(cfg_row(CFG_DEBOUNCE, 16'd2));
    dir_rows.push_back(cfg_row(CFG_SAMPLE, 16'd1));
    dir_rows.push_back(cfg_row(CFG_RECOVERY, 16'd3));
    dir_rows.push_back(cfg_row(CFG_DUTY_0, 16'h00A5));
    dir_rows.push_back(cfg_row(CFG_DUTY_1, 16'h005A));
    dir_rows.push_back(cfg_row(CFG_DUTY_2, 16'h00FF));
    // Readings equal to a threshold pass; two low checks in a row trip.
    dir_rows.push_back(tick_row(12'd2048, 12'd1024, 1'b0, '0, 1'b0));
    dir_rows.push_back(tick_row(12'd2047, 12'hFFF, 1'b0, '0, 1'b0));
    dir_rows.push_back(tick_row(12'd0, 12'd1023, 1'b0, '0, 1'b0));
    // Hold has no effect outside running; a command in error waits for recovery.
    dir_rows.push_back(tick_row(12'd0, 12'd0, 1'b0, '0, 1'b1));
    dir_rows.push_back(tick_row(12'hFFF, 12'hFFF, 1'b1, {8'h11, 8'h22, 8'h33}, 1'b0));
    dir_rows.push_back(tick_row(12'hFFF, 12'hFFF, 1'b0, '0, 1'b0));
    dir_rows.push_back(tick_row(12'hFFF, 12'hFFF, 1'b0, '0, 1'b1));
    dir_rows.push_back(tick_row(12'hFFF, 12'hFFF, 1'b0, '0, 1'b0));
    dir_rows.push_back(tick_row(12'd0, 12'd0, 1'b0, '0, 1'b1));
    dir_rows.push_back(tick_row(12'd100, 12'd2000, 1'b0, '0, 1'b0));
    dir_rows.push_back(tick_row(12'd3000, 12'd5, 1'b0, '0, 1'b0));
    dir_rows.push_back(tick_row(12'd3000, 12'd3000, 1'b0, '0, 1'b0));
    dir_rows.push_back(tick_row(12'd3000, 12'd3000, 1'b1, {8'hC3, 8'h3C, 8'h96}, 1'b0));
    dir_rows.push_back(tick_row(12'd3000, 12'd3000, 1'b0, '0, 1'b0));
    dir_rows.push_back(tick_row(12'd1, 12'd3000, 1'b0, '0, 1'b0));
    // Zero debounce, zero intervals and a disabled rail A.
    dir_rows.push_back(cfg_row(CFG_DEBOUNCE, 16'd0));
    dir_rows.push_back(cfg_row(CFG_SAMPLE, 16'd0));
    dir_rows.push_back(cfg_row(CFG_RECOVERY, 16'd0));
    dir_rows.push_back(cfg_row(CFG_UV_A, 16'd0));
    dir_rows.push_back(tick_row(12'd0, 12'hFFF, 1'b0, '0, 1'b0));
    dir_rows.push_back(tick_row(12'd0, 12'd0, 1'b0, '0, 1'b0));
    dir_rows.push_back(tick_row(12'd0, 12'd1024, 1'b0, '0, 1'b0));
    dir_rows.push_back(tick_row(12'd0, 12'd1024, 1'b0, '0, 1'b0));

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (!cfg_we) settle();
        write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      end else begin
        if (cfg_we) cfg_we <= 1'b0;
        send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
        maybe_gap();
      end
    end

    for (int p = 0; p < 6; p++) begin
      settle();
      program_phase(p);
      cfg_we <= 1'b0;
      for (int n = 0; n < PHASE_TICKS; n++) begin
        send_tick(random_tick(), 1'b0, '0);
        maybe_gap();
      end
    end

    in_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_mismatch == 0 && status_due.size() == 0) begin
      $display("undervoltage_protection_fsm: match");
    end else begin
      $display("undervoltage_protection_fsm: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/uvp_pkg.sv
sv/undervoltage_protection_fsm.sv
tb/tb_undervoltage_protection_fsm.sv
